[hw/rtl/ucdhs_pkg.sv]
// ============================================================================
// ucdhs_pkg
// Shared types and constants of the configuration descriptor HID scanner.
// ============================================================================
package ucdhs_pkg;

    // Item action codes
    localparam logic [1:0] ACT_CONFIG_BYTE = 2'd0;
    localparam logic [1:0] ACT_DEVICE_DONE = 2'd1;
    localparam logic [1:0] ACT_REPORT_DONE = 2'd2;
    localparam logic [1:0] ACT_NONE        = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;

    // Descriptor constants
    localparam logic [7:0] TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] CLASS_HID      = 8'd3;
    localparam logic [7:0] IFACE_MIN_LEN  = 8'd9;
    localparam logic [7:0] HDR_LEN        = 8'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  data_byte;
        logic [15:0] byte_count;
        logic [7:0]  iface_number;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] hid_count;
        logic [2:0] slot_index;
        logic       all_ready;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_CONFIG,
        KIND_DEVICE,
        KIND_REPORT,
        KIND_NONE
    } t_kind;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        t_kind       kind;
        logic        len_ok;
        logic [7:0]  data_byte;
        logic [15:0] byte_count;
        logic [7:0]  iface_number;
        logic        last;
    } t_cmd;

endpackage

[hw/rtl/ucdhs_fifo.sv]
// ============================================================================
// ucdhs_fifo
// Two-entry queue with push/full and pop/empty; push and pop may share a cycle.
// ============================================================================
module ucdhs_fifo #(
    parameter type T = logic [0:0]
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    T           r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hw/rtl/ucdhs_front.sv]
// ============================================================================
// ucdhs_front
// Accept items, decode the action and check the declared length, then queue.
// ============================================================================
module ucdhs_front #(
    parameter int CONFIG_MAX_BYTES = 2048,
    parameter int REPORT_MAX_BYTES = 1024,
    parameter int DEVICE_MAX_BYTES = 18
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ucdhs_pkg::t_in_item i_item,
    output logic                o_full,
    output logic                o_cmd_valid,
    output ucdhs_pkg::t_cmd     o_cmd,
    input  logic                i_cmd_take
);
    import ucdhs_pkg::*;

    t_cmd cmd;
    logic cmd_empty;
    logic [15:0] limit;

    always_comb begin
        cmd.data_byte    = i_item.data_byte;
        cmd.byte_count   = i_item.byte_count;
        cmd.iface_number = i_item.iface_number;
        cmd.last         = i_item.last;
        unique case (i_item.action)
            ACT_CONFIG_BYTE: begin
                cmd.kind = KIND_CONFIG;
                limit    = 16'(CONFIG_MAX_BYTES);
            end
            ACT_DEVICE_DONE: begin
                cmd.kind = KIND_DEVICE;
                limit    = 16'(DEVICE_MAX_BYTES);
            end
            ACT_REPORT_DONE: begin
                cmd.kind = KIND_REPORT;
                limit    = 16'(REPORT_MAX_BYTES);
            end
            default: begin
                cmd.kind = KIND_NONE;
                limit    = 16'hFFFF;
            end
        endcase
        cmd.len_ok = (i_item.byte_count != 16'd0) && (i_item.byte_count <= limit);
    end

    ucdhs_fifo #(
        .T(t_cmd)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_take),
        .o_data  (o_cmd),
        .o_empty (cmd_empty)
    );

    assign o_cmd_valid = !cmd_empty;

endmodule

[hw/rtl/ucdhs_back.sv]
// ============================================================================
// ucdhs_back
// Walk the descriptor stream, keep the HID interface table and ready flags,
// and queue one result per item.
// ============================================================================
module ucdhs_back #(
    parameter int HID_SLOTS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  ucdhs_pkg::t_cmd      i_cmd,
    output logic                 o_cmd_take,
    output logic                 o_empty,
    input  logic                 i_pop,
    output ucdhs_pkg::t_out_item o_result
);
    import ucdhs_pkg::*;

    localparam int SLOT_W = (HID_SLOTS > 1) ? $clog2(HID_SLOTS) : 1;

    logic [7:0]  r_table [HID_SLOTS];
    logic [3:0]  r_slot_count, n_slot_count;
    logic [7:0]  r_ready, n_ready;
    logic        r_dev, n_dev;
    logic        r_cfg, n_cfg;
    logic [15:0] r_off, n_off;
    logic [15:0] r_start, n_start;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_ifc, n_ifc;
    logic        r_stop, n_stop;

    logic              tbl_we;
    logic [SLOT_W-1:0] tbl_wa;
    logic [7:0]        tbl_wd;
    logic              exec;
    logic              out_full;
    t_out_item         result;

    assign exec       = i_cmd_valid && !out_full;
    assign o_cmd_take = exec;

    always_comb begin
        logic        fresh;
        logic [3:0]  e_cnt;
        logic        e_stop;
        logic [15:0] e_start;
        logic [7:0]  e_len;
        logic [7:0]  e_type;
        logic [7:0]  e_ifc;
        logic [16:0] off17;
        logic [16:0] tot17;
        logic [15:0] rel;
        logic [7:0]  b;
        logic        hdr_bad;
        logic        found;
        logic [2:0]  idx;
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [7:0]  ok_bits;

        n_slot_count = r_slot_count;
        n_ready      = r_ready;
        n_dev        = r_dev;
        n_cfg        = r_cfg;
        n_off        = r_off;
        n_start      = r_start;
        n_len        = r_len;
        n_type       = r_type;
        n_ifc        = r_ifc;
        n_stop       = r_stop;
        tbl_we       = 1'b0;
        tbl_wa       = SLOT_W'(r_slot_count);
        tbl_wd       = i_cmd.iface_number;
        status       = ST_OK;
        slot         = 3'd0;
        found        = 1'b0;
        idx          = 3'd0;

        // Stream start restarts the scan and empties the table
        fresh   = (r_off == 16'd0);
        e_cnt   = fresh ? 4'd0  : r_slot_count;
        e_stop  = fresh ? 1'b0  : r_stop;
        e_start = fresh ? 16'd0 : r_start;
        e_len   = fresh ? 8'd0  : r_len;
        e_type  = fresh ? 8'd0  : r_type;
        e_ifc   = fresh ? 8'd0  : r_ifc;

        b       = i_cmd.data_byte;
        off17   = {1'b0, r_off};
        tot17   = {1'b0, i_cmd.byte_count};
        rel     = r_off - e_start;
        hdr_bad = (off17 + 17'(HDR_LEN) > tot17) || (b < HDR_LEN) ||
                  (off17 + {9'd0, b} > tot17);

        unique case (i_cmd.kind)
            KIND_CONFIG: begin
                if (!i_cmd.len_ok) begin
                    status = ST_BAD_LEN;
                end else begin
                    n_slot_count = e_cnt;
                    n_stop       = e_stop;
                    n_start      = e_start;
                    n_len        = e_len;
                    n_type       = e_type;
                    n_ifc        = e_ifc;
                    if (!e_stop && off17 < tot17 && r_off >= e_start) begin
                        if (rel == 16'd0 && hdr_bad) begin
                            n_stop = 1'b1;
                        end else begin
                            if (rel == 16'd0) begin
                                n_len = b;
                            end
                            if (rel == 16'd1) begin
                                n_type = b;
                            end
                            if (rel == 16'd2) begin
                                n_ifc = b;
                            end
                            if (rel == 16'd5 && e_type == TYPE_INTERFACE &&
                                e_len >= IFACE_MIN_LEN && b == CLASS_HID &&
                                e_cnt < 4'(HID_SLOTS)) begin
                                tbl_we       = 1'b1;
                                tbl_wa       = SLOT_W'(e_cnt);
                                tbl_wd       = e_ifc;
                                n_slot_count = e_cnt + 4'd1;
                            end
                            // Advance to the next sub-descriptor on its last byte
                            if ({1'b0, rel} + 17'd1 >= {9'd0, n_len}) begin
                                n_start = r_off + 16'd1;
                            end
                        end
                    end
                    if (r_off != 16'hFFFF) begin
                        n_off = r_off + 16'd1;
                    end
                    if (i_cmd.last) begin
                        n_cfg = 1'b1;
                    end
                end
                if (i_cmd.last) begin
                    n_off = 16'd0;
                end
            end
            KIND_DEVICE: begin
                if (!i_cmd.len_ok) begin
                    status = ST_BAD_LEN;
                end else begin
                    n_dev = 1'b1;
                end
            end
            KIND_REPORT: begin
                if (!i_cmd.len_ok) begin
                    status = ST_BAD_LEN;
                end else begin
                    // Lowest matching slot wins
                    for (int i = HID_SLOTS - 1; i >= 0; i--) begin
                        if (4'(i) < r_slot_count && r_table[i] == i_cmd.iface_number) begin
                            found = 1'b1;
                            idx   = 3'(i);
                        end
                    end
                    if (found) begin
                        slot = idx;
                    end else if (r_slot_count < 4'(HID_SLOTS)) begin
                        tbl_we       = 1'b1;
                        slot         = r_slot_count[2:0];
                        n_slot_count = r_slot_count + 4'd1;
                    end else begin
                        status = ST_NO_SLOT;
                    end
                    if (status == ST_OK) begin
                        n_ready = r_ready | (8'd1 << slot);
                    end
                end
            end
            default: begin
            end
        endcase

        for (int i = 0; i < 8; i++) begin
            ok_bits[i] = n_ready[i] || (4'(i) >= n_slot_count);
        end

        result.status     = status;
        result.hid_count  = n_slot_count;
        result.slot_index = slot;
        result.all_ready  = n_dev && n_cfg && (&ok_bits);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= 4'd0;
            r_ready      <= 8'd0;
            r_dev        <= 1'b0;
            r_cfg        <= 1'b0;
            r_off        <= 16'd0;
            r_start      <= 16'd0;
            r_len        <= 8'd0;
            r_type       <= 8'd0;
            r_ifc        <= 8'd0;
            r_stop       <= 1'b0;
        end else if (exec) begin
            r_slot_count <= n_slot_count;
            r_ready      <= n_ready;
            r_dev        <= n_dev;
            r_cfg        <= n_cfg;
            r_off        <= n_off;
            r_start      <= n_start;
            r_len        <= n_len;
            r_type       <= n_type;
            r_ifc        <= n_ifc;
            r_stop       <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && tbl_we) begin
            r_table[tbl_wa] <= tbl_wd;
        end
    end

    ucdhs_fifo #(
        .T(t_out_item)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (exec),
        .i_data  (result),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

endmodule

[hw/rtl/usb_config_descriptor_hid_scanner_top.sv]
// ============================================================================
// usb_config_descriptor_hid_scanner_top
// USB configuration descriptor scanner that tracks HID interfaces and readiness.
// ============================================================================
// Each accepted item yields exactly one result. The block takes one item per
// cycle and returns one result per cycle when pop keeps up. An item enters the
// command queue at the edge that accepts it. Once the result queue has room, the
// executing stage moves it into the result queue, and its result is then on the
// output. The rate is set by the executing stage, which updates the whole scan
// state, the interface table and the ready flags together for each item. Both
// queues hold two items, so either side can stall without stopping the other.
// No clearing pass runs after reset.
module usb_config_descriptor_hid_scanner_top #(
    parameter int HID_SLOTS        = 8,
    parameter int CONFIG_MAX_BYTES = 2048,
    parameter int REPORT_MAX_BYTES = 1024,
    parameter int DEVICE_MAX_BYTES = 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  ucdhs_pkg::t_in_item  i_item,
    output logic                 empty,
    input  logic                 pop,
    output ucdhs_pkg::t_out_item o_result
);
    import ucdhs_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_take;

    ucdhs_front #(
        .CONFIG_MAX_BYTES (CONFIG_MAX_BYTES),
        .REPORT_MAX_BYTES (REPORT_MAX_BYTES),
        .DEVICE_MAX_BYTES (DEVICE_MAX_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    ucdhs_back #(
        .HID_SLOTS (HID_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule
